@@ src/sbtl_pkg.sv @@
package sbtl_pkg;

  // Field widths of the request and result channels
  localparam int unsigned KEY_W = 64;
  localparam int unsigned VAL_W = 64;
  localparam int unsigned POS_W = 12;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned STATUS_W = 3;

  // Default table geometry
  localparam int unsigned DEF_ENTRIES_PER_BLOCK = 256;
  localparam int unsigned DEF_MAX_ENTRIES = 4096;

  // Request operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_LOOKUP = 2'd2
  } func_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_NOT_FOUND = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_ORDER     = 3'd4
  } status_e;

endpackage

@@ src/sbtl_table_mem.sv @@
module sbtl_table_mem #(
  parameter int unsigned DEPTH = sbtl_pkg::DEF_MAX_ENTRIES,
  parameter int unsigned AW    = 12
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [AW-1:0]              wr_addr_i,
  input  logic [sbtl_pkg::KEY_W-1:0] wr_key_i,
  input  logic [sbtl_pkg::VAL_W-1:0] wr_value_i,
  input  logic                       rd_en_i,
  input  logic [AW-1:0]              rd_addr_i,
  output logic [sbtl_pkg::KEY_W-1:0] rd_key_o,
  output logic [sbtl_pkg::VAL_W-1:0] rd_value_o
);
  import sbtl_pkg::*;

  logic [KEY_W-1:0] key_mem [DEPTH];
  logic [VAL_W-1:0] val_mem [DEPTH];
  logic [KEY_W-1:0] rd_key_q;
  logic [VAL_W-1:0] rd_value_q;

  // Write the appended entry
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_mem[wr_addr_i] <= wr_key_i;
      val_mem[wr_addr_i] <= wr_value_i;
    end
  end

  // Read key and value of one entry, data registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_key_q   <= key_mem[rd_addr_i];
      rd_value_q <= val_mem[rd_addr_i];
    end
  end

  assign rd_key_o   = rd_key_q;
  assign rd_value_o = rd_value_q;

endmodule

@@ src/sorted_block_table_lookup.sv @@
// Sorted key to value table with a two-level lookup.
// Request channel (in_valid_i / in_stall_o) carries func_i, key_i and value_i;
// result channel (out_valid_o / out_stall_i) carries status_o, found_value_o
// and entry_position_o. Every request yields exactly one result, in order.
// Clear, append, unknown operations and lookups decided by the first/last key
// bounds give their result in the cycle after the request is taken.
// A full lookup binary searches the block start keys, then the entries of the
// chosen block. Each probe is one read of the entry memory (S_BLK or S_ENT)
// followed by one compare (S_BLK_CMP or S_ENT_CMP); the result, hit or miss,
// then waits in S_RESP until the output register is free.
// One request is in work at a time; the next request is taken once the
// current result sits in the output register and that register is free.
// A stalled result holds in the output register; new requests stall
// while it waits. Reset empties the table at once (count and last key go to
// zero); memory contents are left as they are and never read before written.
module sorted_block_table_lookup #(
  parameter int unsigned ENTRIES_PER_BLOCK = sbtl_pkg::DEF_ENTRIES_PER_BLOCK,
  parameter int unsigned MAX_ENTRIES       = sbtl_pkg::DEF_MAX_ENTRIES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sbtl_pkg::FUNC_W-1:0]   func_i,
  input  logic [sbtl_pkg::KEY_W-1:0]    key_i,
  input  logic [sbtl_pkg::VAL_W-1:0]    value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sbtl_pkg::STATUS_W-1:0] status_o,
  output logic [sbtl_pkg::VAL_W-1:0]    found_value_o,
  output logic [sbtl_pkg::POS_W-1:0]    entry_position_o
);
  import sbtl_pkg::*;

  localparam int unsigned AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned NBLK = (MAX_ENTRIES + ENTRIES_PER_BLOCK - 1) / ENTRIES_PER_BLOCK;
  localparam int unsigned BW   = (NBLK > 1) ? $clog2(NBLK) : 1;
  localparam int unsigned OW   = (ENTRIES_PER_BLOCK > 1) ? $clog2(ENTRIES_PER_BLOCK) : 1;
  localparam int unsigned SW   = $clog2(ENTRIES_PER_BLOCK + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BLK,
    S_BLK_CMP,
    S_ENT,
    S_ENT_CMP,
    S_RESP
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   count_q;
  logic [KEY_W-1:0] first_key_q;
  logic [KEY_W-1:0] last_key_q;
  logic [BW-1:0]   last_blk_q;
  logic [OW-1:0]   last_off_q;
  logic [KEY_W-1:0] target_q;
  logic [BW-1:0]   lo_q;
  logic [BW-1:0]   hi_q;
  logic [BW-1:0]   blk_mid_q;
  logic [AW-1:0]   base_q;
  logic [SW-1:0]   a_q;
  logic [SW-1:0]   b_q;
  logic [SW-1:0]   ent_mid_q;
  status_e         res_status_q;
  logic [VAL_W-1:0] res_value_q;
  logic [POS_W-1:0] res_pos_q;
  logic            out_valid_q;
  status_e         status_q;
  logic [VAL_W-1:0] found_value_q;
  logic [POS_W-1:0] entry_position_q;

  logic            out_free;
  logic            accept;
  logic            is_empty;
  logic            is_full;
  logic            append_ok;
  logic [BW:0]     blk_diff;
  logic [BW-1:0]   blk_mid;
  logic [SW-1:0]   ent_mid;
  logic [SW-1:0]   last_span;
  logic [AW-1:0]   blk_addr;
  logic [AW-1:0]   ent_addr;
  logic [AW-1:0]   hit_addr;
  logic [AW-1:0]   app_addr;
  logic [AW+POS_W-1:0] hit_pos_wide;
  logic [AW+POS_W-1:0] app_pos_wide;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_value;

  // Request handshake: take one request at a time, only with room for its result
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  // Table status and append checks
  assign is_empty  = (count_q == '0);
  assign is_full   = (count_q == CW'(MAX_ENTRIES));
  assign append_ok = !is_full && (is_empty || (key_i > last_key_q));
  assign app_addr  = count_q[AW-1:0];
  assign wr_en     = accept && (func_i == FUNC_APPEND) && append_ok;

  // Probe points of both binary searches
  assign blk_diff  = {1'b0, hi_q} - {1'b0, lo_q} + (BW+1)'(1);
  assign blk_mid   = lo_q + BW'(blk_diff >> 1);
  assign ent_mid   = a_q + ((b_q - a_q) >> 1);
  assign last_span = SW'(last_off_q) + SW'(1);
  assign blk_addr  = AW'(blk_mid * ENTRIES_PER_BLOCK);
  assign ent_addr  = AW'(base_q + ent_mid);
  assign hit_addr  = AW'(base_q + ent_mid_q);

  // Reported positions keep the low bits of the entry address
  assign hit_pos_wide = {{POS_W{1'b0}}, hit_addr};
  assign app_pos_wide = {{POS_W{1'b0}}, app_addr};

  // Issue one memory read per probe
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = blk_addr;
    if (state_q == S_BLK) begin
      rd_en   = (lo_q < hi_q);
      rd_addr = blk_addr;
    end else if (state_q == S_ENT) begin
      rd_en   = (a_q < b_q);
      rd_addr = ent_addr;
    end
  end

  sbtl_table_mem #(
    .DEPTH(MAX_ENTRIES),
    .AW   (AW)
  ) u_table_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (app_addr),
    .wr_key_i  (key_i),
    .wr_value_i(value_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_key_o  (rd_key),
    .rd_value_o(rd_value)
  );

  // Sequence requests, searches and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      count_q          <= '0;
      first_key_q      <= '0;
      last_key_q       <= '0;
      last_blk_q       <= '0;
      last_off_q       <= '0;
      target_q         <= '0;
      lo_q             <= '0;
      hi_q             <= '0;
      blk_mid_q        <= '0;
      base_q           <= '0;
      a_q              <= '0;
      b_q              <= '0;
      ent_mid_q        <= '0;
      res_status_q     <= STAT_OK;
      res_value_q      <= '0;
      res_pos_q        <= '0;
      out_valid_q      <= 1'b0;
      status_q         <= STAT_OK;
      found_value_q    <= '0;
      entry_position_q <= '0;
    end else begin
      // Drop a result once taken
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            out_valid_q      <= 1'b1;
            status_q         <= STAT_OK;
            found_value_q    <= '0;
            entry_position_q <= '0;
            case (func_i)
              FUNC_CLEAR: begin
                count_q    <= '0;
                last_key_q <= '0;
              end
              FUNC_APPEND: begin
                if (is_full) begin
                  status_q <= STAT_FULL;
                end else if (!append_ok) begin
                  status_q <= STAT_ORDER;
                end else begin
                  entry_position_q <= app_pos_wide[POS_W-1:0];
                  count_q          <= CW'(count_q + CW'(1));
                  last_key_q       <= key_i;
                  if (is_empty) begin
                    first_key_q <= key_i;
                    last_blk_q  <= '0;
                    last_off_q  <= '0;
                  end else if (last_off_q == OW'(ENTRIES_PER_BLOCK - 1)) begin
                    last_blk_q <= BW'(last_blk_q + BW'(1));
                    last_off_q <= '0;
                  end else begin
                    last_off_q <= OW'(last_off_q + OW'(1));
                  end
                end
              end
              FUNC_LOOKUP: begin
                if (is_empty) begin
                  status_q <= STAT_EMPTY;
                end else if ((key_i < first_key_q) || (key_i > last_key_q)) begin
                  status_q <= STAT_NOT_FOUND;
                end else begin
                  // Hold the result back and start the block search
                  out_valid_q <= 1'b0;
                  target_q    <= key_i;
                  lo_q        <= '0;
                  hi_q        <= last_blk_q;
                  state_q     <= S_BLK;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_BLK: begin
          if (lo_q < hi_q) begin
            blk_mid_q <= blk_mid;
            state_q   <= S_BLK_CMP;
          end else begin
            base_q  <= AW'(lo_q * ENTRIES_PER_BLOCK);
            a_q     <= '0;
            b_q     <= (lo_q == last_blk_q) ? last_span : SW'(ENTRIES_PER_BLOCK);
            state_q <= S_ENT;
          end
        end
        S_BLK_CMP: begin
          if (rd_key <= target_q) begin
            lo_q <= blk_mid_q;
          end else begin
            hi_q <= BW'(blk_mid_q - BW'(1));
          end
          state_q <= S_BLK;
        end
        S_ENT: begin
          if (a_q < b_q) begin
            ent_mid_q <= ent_mid;
            state_q   <= S_ENT_CMP;
          end else begin
            res_status_q <= STAT_NOT_FOUND;
            res_value_q  <= '0;
            res_pos_q    <= '0;
            state_q      <= S_RESP;
          end
        end
        S_ENT_CMP: begin
          if (rd_key < target_q) begin
            a_q     <= SW'(ent_mid_q + SW'(1));
            state_q <= S_ENT;
          end else if (rd_key > target_q) begin
            b_q     <= ent_mid_q;
            state_q <= S_ENT;
          end else begin
            res_status_q <= STAT_OK;
            res_value_q  <= rd_value;
            res_pos_q    <= hit_pos_wide[POS_W-1:0];
            state_q      <= S_RESP;
          end
        end
        S_RESP: begin
          // Wait for the output register, then hand the result over
          if (out_free) begin
            out_valid_q      <= 1'b1;
            status_q         <= res_status_q;
            found_value_q    <= res_value_q;
            entry_position_q <= res_pos_q;
            state_q          <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign found_value_o    = found_value_q;
  assign entry_position_o = entry_position_q;

endmodule

@@ tb/sbtl_tb_pkg.sv @@
package sbtl_tb_pkg;
  import sbtl_pkg::*;

  // Selector value the block leaves unused
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam int unsigned BLOCK_LEN = DEF_ENTRIES_PER_BLOCK;
  localparam int unsigned CAPACITY  = DEF_MAX_ENTRIES;

  typedef struct packed {
    status_e          status;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] pos;
  } lookup_result_t;

  class table_scoreboard;
    bit [KEY_W-1:0] keys [CAPACITY];
    bit [VAL_W-1:0] vals [CAPACITY];
    int unsigned    count;
    bit [KEY_W-1:0] last_key;

    lookup_result_t awaited [$];
    int unsigned    errors;
    int unsigned    requests;
    int unsigned    results;
    int unsigned    status_seen [5];

    // Find the block by its first key, then bisect inside the block
    function lookup_result_t search(bit [KEY_W-1:0] target);
      lookup_result_t r;
      int unsigned    lo, hi, mid, base, span, a, b;
      r = '{status: STAT_NOT_FOUND, value: '0, pos: '0};
      if (count == 0) begin
        r.status = STAT_EMPTY;
        return r;
      end
      if (target < keys[0] || target > last_key) return r;
      lo = 0;
      hi = (count + BLOCK_LEN - 1) / BLOCK_LEN - 1;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        if (keys[mid * BLOCK_LEN] <= target) lo = mid;
        else hi = mid - 1;
      end
      base = lo * BLOCK_LEN;
      span = count - base;
      if (span > BLOCK_LEN) span = BLOCK_LEN;
      a = 0;
      b = span;
      while (a < b) begin
        mid = a + (b - a) / 2;
        if (keys[base + mid] < target) a = mid + 1;
        else if (keys[base + mid] > target) b = mid;
        else begin
          r.status = STAT_OK;
          r.value  = vals[base + mid];
          r.pos    = POS_W'(base + mid);
          return r;
        end
      end
      return r;
    endfunction

    // Update the table for an accepted request and queue its result
    function void note_request(logic [FUNC_W-1:0] func, bit [KEY_W-1:0] key,
                               bit [VAL_W-1:0] value);
      lookup_result_t r;
      r = '{status: STAT_OK, value: '0, pos: '0};
      case (func)
        FUNC_CLEAR: begin
          count    = 0;
          last_key = '0;
        end
        FUNC_APPEND: begin
          if (count >= CAPACITY) r.status = STAT_FULL;
          else if (count != 0 && key <= last_key) r.status = STAT_ORDER;
          else begin
            keys[count] = key;
            vals[count] = value;
            last_key    = key;
            r.pos       = POS_W'(count);
            count++;
          end
        end
        FUNC_LOOKUP: r = search(key);
        default: ;
      endcase
      awaited.push_back(r);
      requests++;
      status_seen[r.status]++;
    endfunction

    // Compare a delivered result with the oldest queued one
    function void check_result(logic [STATUS_W-1:0] status, logic [VAL_W-1:0] value,
                               logic [POS_W-1:0] pos);
      lookup_result_t e;
      results++;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result: status %0d value %h position %0d",
                 $time, status, value, pos);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (status !== e.status) begin
        $display("%0t: status mismatch: expected %0d, got %0d", $time, e.status, status);
        errors++;
      end
      if (value !== e.value) begin
        $display("%0t: found_value mismatch: expected %h, got %h", $time, e.value, value);
        errors++;
      end
      if (pos !== e.pos) begin
        $display("%0t: entry_position mismatch: expected %0d, got %0d", $time, e.pos, pos);
        errors++;
      end
    endfunction
  endclass

endpackage

@@ tb/tb_top.sv @@
module tb_top;
  import sbtl_pkg::*;
  import sbtl_tb_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 960;
  localparam int unsigned FILL_ENTRIES   = 600;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned DRAIN_CYCLES   = 40;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [FUNC_W-1:0]   req_func  = '0;
  logic [KEY_W-1:0]    req_key   = '0;
  logic [VAL_W-1:0]    req_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] res_status;
  logic [VAL_W-1:0]    res_value;
  logic [POS_W-1:0]    res_pos;

  // Suppress idling on both sides while set
  logic quiet    = 1'b0;
  // Ask the result side for one long hold-off
  logic hold_req = 1'b0;

  table_scoreboard sb = new;

  sorted_block_table_lookup dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .func_i           (req_func),
    .key_i            (req_key),
    .value_i          (req_value),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (res_status),
    .found_value_o    (res_value),
    .entry_position_o (res_pos)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Pick a lookup key: stored keys, neighbors, block edges, out of range
  function automatic logic [KEY_W-1:0] probe_key();
    int unsigned    r, idx;
    logic [KEY_W-1:0] k;
    if (sb.count == 0) return rand64();
    r   = $urandom_range(0, 99);
    idx = $urandom_range(0, sb.count - 1);
    if (r < 10) idx = $urandom_range(0, (sb.count - 1) / BLOCK_LEN) * BLOCK_LEN;
    else if (r < 15 && sb.count > BLOCK_LEN)
      idx = $urandom_range(1, (sb.count - 1) / BLOCK_LEN) * BLOCK_LEN - 1;
    else if (r < 20) idx = sb.count - 1;
    k = sb.keys[idx];
    if (r < 55) return k;
    if (r < 70) return $urandom_range(0, 1) ? k + 1 : k - 1;
    if (r < 80) return sb.keys[0] - (sb.keys[0] >> $urandom_range(0, 63)) - 1;
    if (r < 90) return sb.last_key + (~sb.last_key >> $urandom_range(0, 63)) + 1;
    return rand64();
  endfunction

  // Offer one request and hold it until taken
  task automatic send_request(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
                              logic [VAL_W-1:0] v);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_func  <= f;
    req_key   <= k;
    req_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(f, k, v);
  endtask

  task automatic run_directed();
    // Empty table, unused selector
    send_request(FUNC_LOOKUP, '0, rand64());
    send_request(FUNC_LOOKUP, '1, rand64());
    send_request(FUNC_UNUSED, '1, '1);
    // Small table: order refusals, hits, misses on both sides and between
    send_request(FUNC_APPEND, 64'd100, '1);
    send_request(FUNC_APPEND, 64'd100, rand64());
    send_request(FUNC_APPEND, 64'd50, rand64());
    send_request(FUNC_LOOKUP, 64'd100, '0);
    send_request(FUNC_LOOKUP, 64'd99, '0);
    send_request(FUNC_LOOKUP, 64'd101, '0);
    send_request(FUNC_APPEND, 64'd200, '0);
    send_request(FUNC_APPEND, 64'd300, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(FUNC_LOOKUP, 64'd150, '1);
    send_request(FUNC_LOOKUP, 64'd300, '1);
    // Clear, then keys at both extremes
    send_request(FUNC_CLEAR, rand64(), rand64());
    send_request(FUNC_LOOKUP, 64'd100, '0);
    send_request(FUNC_APPEND, '0, 64'h5555_5555_5555_5555);
    send_request(FUNC_APPEND, '0, rand64());
    send_request(FUNC_APPEND, '1, 64'd1);
    send_request(FUNC_APPEND, '1, rand64());
    send_request(FUNC_LOOKUP, '0, '0);
    send_request(FUNC_LOOKUP, '1, '0);
    send_request(FUNC_LOOKUP, 64'd1, '0);
    send_request(FUNC_UNUSED, rand64(), rand64());
    send_request(FUNC_CLEAR, '0, '0);
  endtask

  // Fill the table across several blocks, refuse a stale key, search all blocks
  task automatic fill_phase();
    logic [KEY_W-1:0] cur;
    int unsigned      i;
    quiet <= 1'b0;
    send_request(FUNC_CLEAR, rand64(), rand64());
    hold_req <= 1'b1;
    cur = rand64() >> 8;
    for (i = 0; i < FILL_ENTRIES; i++) begin
      send_request(FUNC_APPEND, cur, rand64());
      cur = cur + (rand64() >> $urandom_range(16, 63)) + 1;
      if (i % 64 == 63) send_request(FUNC_LOOKUP, probe_key(), rand64());
    end
    send_request(FUNC_APPEND, cur, rand64());
    send_request(FUNC_APPEND, '0, rand64());
    send_request(FUNC_UNUSED, rand64(), rand64());
    repeat (100) send_request(FUNC_LOOKUP, probe_key(), rand64());
  endtask

  // Ascending append runs with lookups, plus broken appends and noise
  task automatic random_phase();
    int unsigned      sent, n_app, done, r, step_shift;
    logic [KEY_W-1:0] cur;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      quiet <= ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 75) n_app = $urandom_range(1, 30);
      else if (r < 95) n_app = $urandom_range(31, 300);
      else n_app = $urandom_range(301, 800);
      cur        = rand64() >> $urandom_range(0, 63);
      step_shift = $urandom_range(16, 62);
      if ($urandom_range(0, 9) != 0) begin
        send_request(FUNC_CLEAR, rand64(), rand64());
        sent++;
      end
      done = 0;
      while (done < n_app && sent < RANDOM_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          send_request(FUNC_APPEND, cur, rand64());
          cur = cur + (rand64() >> step_shift) + 1;
          done++;
        end else if (r < 80) begin
          send_request(FUNC_LOOKUP, probe_key(), rand64());
        end else if (r < 87) begin
          send_request(FUNC_APPEND, sb.last_key - (sb.last_key >> $urandom_range(0, 63)),
                       rand64());
        end else if (r < 93) begin
          send_request(FUNC_UNUSED, rand64(), rand64());
        end else if (r < 95) begin
          send_request(FUNC_CLEAR, rand64(), rand64());
        end else begin
          send_request(FUNC_APPEND, rand64(), rand64());
        end
        sent++;
      end
    end
  endtask

  // Drive requests, then drain and report
  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    fill_phase();
    random_phase();
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d requests and %0d results: %0d ok, %0d not found, %0d empty",
             sb.requests, sb.results, sb.status_seen[STAT_OK],
             sb.status_seen[STAT_NOT_FOUND], sb.status_seen[STAT_EMPTY]);
    $display("Refused appends: %0d on a full table, %0d out of order; %0d mismatches",
             sb.status_seen[STAT_FULL], sb.status_seen[STAT_ORDER], sb.errors);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("** sorted_block_table_lookup: PASSED **");
    end else begin
      $display("** sorted_block_table_lookup: FAILED **");
    end
    $finish;
  end

  // Stall the result side at random, with one long hold-off on request
  initial begin : result_sink
    int unsigned stall_left, r;
    bit          hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !quiet) begin
        r = $urandom_range(0, 99);
        if (r < 60) stall_left = 0;
        else if (r < 88) stall_left = $urandom_range(1, 3);
        else if (r < 97) stall_left = $urandom_range(4, 12);
        else stall_left = $urandom_range(20, 60);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
      @(posedge clk);
      if (out_valid && !out_stall) sb.check_result(res_status, res_value, res_pos);
    end
  end

  // End the run when neither channel moves for too long
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("%0t: no transfer for %0d cycles, %0d results outstanding",
             $time, WATCHDOG_LIMIT, sb.awaited.size());
    $display("** sorted_block_table_lookup: FAILED **");
    $finish;
  end

endmodule
